// File: design/tkd_pkg.sv
`default_nettype none
// Shared types and constants for the two-key debounce / long-press core.
// Used by tkd_csr, tkd_step, tkd_evq and the top level.
package tkd_pkg;

   localparam int unsigned CodeWidth  = 4;
   localparam int unsigned ActWidth   = 2;
   localparam int unsigned DebWidth   = 10;
   localparam int unsigned LongWidth  = 16;
   localparam int unsigned AddrWidth  = 5;
   localparam int unsigned DataWidth  = 32;
   localparam int unsigned MaxEvents  = 3;

   localparam logic [ActWidth-1:0] ACT_RELEASE = 2'd0;
   localparam logic [ActWidth-1:0] ACT_PUSH    = 2'd1;
   localparam logic [ActWidth-1:0] ACT_LONG    = 2'd2;

   localparam logic [2:0] REG_SELECT_CODE = 3'd0;
   localparam logic [2:0] REG_NAV_CODE    = 3'd1;
   localparam logic [2:0] REG_PUSH_LEVEL  = 3'd2;
   localparam logic [2:0] REG_DEB_TICKS   = 3'd3;
   localparam logic [2:0] REG_LONG_TICKS  = 3'd4;

   localparam logic [CodeWidth-1:0] RST_SELECT_CODE = 4'd1;
   localparam logic [CodeWidth-1:0] RST_NAV_CODE    = 4'd2;
   localparam logic                 RST_PUSH_LEVEL  = 1'b0;
   localparam logic [DebWidth-1:0]  RST_DEB_TICKS   = 10'd50;
   localparam logic [LongWidth-1:0] RST_LONG_TICKS  = 16'd3000;

   typedef struct packed {
      logic [CodeWidth-1:0] select_key_code;
      logic [CodeWidth-1:0] nav_key_code;
      logic                 push_level;
      logic [DebWidth-1:0]  debounce_ticks;
      logic [LongWidth-1:0] long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           previous_levels;
      logic [1:0]           recorded_levels;
      logic [1:0]           pending_marks;
      logic [DebWidth-1:0]  debounce_count;
      logic                 debounce_running;
      logic [LongWidth-1:0] long_count;
      logic                 long_running;
      logic [CodeWidth-1:0] long_key;
   } state_type;

   typedef struct packed {
      logic [CodeWidth-1:0] key_code;
      logic [ActWidth-1:0]  key_action;
      logic                 last_event;
   } evt_type;

   localparam state_type STATE_RESET = '{
      previous_levels:  2'b11,
      recorded_levels:  2'b00,
      pending_marks:    2'b00,
      debounce_count:   '0,
      debounce_running: 1'b0,
      long_count:       '0,
      long_running:     1'b0,
      long_key:         '0
   };

endpackage
`default_nettype wire

// File: design/tkd_csr.sv
`default_nettype none
// Configuration register file behind the APB-style port.
// Depends on tkd_pkg for register codes, reset values and cfg_type.
module tkd_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [tkd_pkg::AddrWidth-1:0]  csr_paddr,
   input  wire logic [tkd_pkg::DataWidth-1:0]  csr_pwdata,
   output logic      [tkd_pkg::DataWidth-1:0]  csr_prdata,
   output logic                                csr_pready,
   output tkd_pkg::cfg_type                    cfg
);

   tkd_pkg::cfg_type cfg_ff;
   tkd_pkg::cfg_type cfg_in;
   logic [2:0]       reg_idx;
   logic             wr_en;

   assign reg_idx    = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            tkd_pkg::REG_SELECT_CODE:
               cfg_in.select_key_code = csr_pwdata[tkd_pkg::CodeWidth-1:0];
            tkd_pkg::REG_NAV_CODE:
               cfg_in.nav_key_code = csr_pwdata[tkd_pkg::CodeWidth-1:0];
            tkd_pkg::REG_PUSH_LEVEL:
               cfg_in.push_level = csr_pwdata[0];
            tkd_pkg::REG_DEB_TICKS:
               cfg_in.debounce_ticks = csr_pwdata[tkd_pkg::DebWidth-1:0];
            tkd_pkg::REG_LONG_TICKS:
               cfg_in.long_press_ticks = csr_pwdata[tkd_pkg::LongWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.select_key_code  <= tkd_pkg::RST_SELECT_CODE;
         cfg_ff.nav_key_code     <= tkd_pkg::RST_NAV_CODE;
         cfg_ff.push_level       <= tkd_pkg::RST_PUSH_LEVEL;
         cfg_ff.debounce_ticks   <= tkd_pkg::RST_DEB_TICKS;
         cfg_ff.long_press_ticks <= tkd_pkg::RST_LONG_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         tkd_pkg::REG_SELECT_CODE:
            csr_prdata = {{(tkd_pkg::DataWidth-tkd_pkg::CodeWidth){1'b0}},
                          cfg_ff.select_key_code};
         tkd_pkg::REG_NAV_CODE:
            csr_prdata = {{(tkd_pkg::DataWidth-tkd_pkg::CodeWidth){1'b0}},
                          cfg_ff.nav_key_code};
         tkd_pkg::REG_PUSH_LEVEL:
            csr_prdata = {{(tkd_pkg::DataWidth-1){1'b0}}, cfg_ff.push_level};
         tkd_pkg::REG_DEB_TICKS:
            csr_prdata = {{(tkd_pkg::DataWidth-tkd_pkg::DebWidth){1'b0}},
                          cfg_ff.debounce_ticks};
         tkd_pkg::REG_LONG_TICKS:
            csr_prdata = {{(tkd_pkg::DataWidth-tkd_pkg::LongWidth){1'b0}},
                          cfg_ff.long_press_ticks};
         default:
            csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

// File: design/tkd_step.sv
`default_nettype none
// Next-state and event logic for one tick: long timer, debounce expiry, edges.
// Depends on tkd_pkg for state_type, cfg_type, evt_type and action codes.
module tkd_step (
   input  wire tkd_pkg::state_type             state_cur,
   input  wire tkd_pkg::cfg_type               cfg,
   input  wire logic                           select_level,
   input  wire logic                           nav_level,
   output tkd_pkg::state_type                  state_nxt,
   output tkd_pkg::evt_type [tkd_pkg::MaxEvents-1:0] evts,
   output logic [1:0]                          evt_count
);

   always_comb begin
      tkd_pkg::state_type s;
      tkd_pkg::evt_type   slot [tkd_pkg::MaxEvents];
      logic [tkd_pkg::MaxEvents-1:0] slot_v;
      logic [1:0]                    lvl;
      logic [tkd_pkg::CodeWidth-1:0] code;
      logic [1:0]                    k;

      s      = state_cur;
      lvl    = {nav_level, select_level};
      code   = '0;
      slot_v = '0;
      for (int i = 0; i < tkd_pkg::MaxEvents; i++) begin
         slot[i] = '0;
      end

      // advance long-press timer
      if (s.long_running) begin
         if (s.long_count <= 16'd1) begin
            s.long_running = 1'b0;
            s.long_count   = '0;
            slot_v[0]      = 1'b1;
            slot[0].key_code   = s.long_key;
            slot[0].key_action = tkd_pkg::ACT_LONG;
         end else begin
            s.long_count = s.long_count - 16'd1;
         end
      end

      // advance debounce timer, settle select then nav
      if (s.debounce_running) begin
         if (s.debounce_count <= 10'd1) begin
            s.debounce_running = 1'b0;
            s.debounce_count   = '0;
            for (int b = 0; b < 2; b++) begin
               code = (b == 0) ? cfg.select_key_code : cfg.nav_key_code;
               if (s.pending_marks[b]) begin
                  s.pending_marks[b] = 1'b0;
                  if (s.recorded_levels[b] == lvl[b]) begin
                     slot_v[b+1]          = 1'b1;
                     slot[b+1].key_code   = code;
                     if (lvl[b] == cfg.push_level) begin
                        s.long_count   = cfg.long_press_ticks;
                        s.long_running = 1'b1;
                        s.long_key     = code;
                        slot[b+1].key_action = tkd_pkg::ACT_PUSH;
                     end else begin
                        s.long_running = 1'b0;
                        slot[b+1].key_action = tkd_pkg::ACT_RELEASE;
                     end
                  end
               end
            end
         end else begin
            s.debounce_count = s.debounce_count - 10'd1;
         end
      end

      // handle edges, select first
      for (int b = 0; b < 2; b++) begin
         if (s.previous_levels[b] != lvl[b]) begin
            s.previous_levels[b] = lvl[b];
            s.debounce_running   = 1'b0;
            if (!s.pending_marks[b]) begin
               s.recorded_levels[b] = lvl[b];
               s.pending_marks[b]   = 1'b1;
               s.debounce_count     = cfg.debounce_ticks;
               s.debounce_running   = 1'b1;
            end else begin
               s.pending_marks[b] = 1'b0;
            end
         end
      end

      // pack events in order, mark the final one
      evts = '0;
      k    = 2'd0;
      for (int i = 0; i < tkd_pkg::MaxEvents; i++) begin
         if (slot_v[i]) begin
            evts[k] = slot[i];
            k       = k + 2'd1;
         end
      end
      if (k != 2'd0) begin
         evts[k - 2'd1].last_event = 1'b1;
      end

      evt_count = k;
      state_nxt = s;
   end

endmodule
`default_nettype wire

// File: design/tkd_evq.sv
`default_nettype none
// Event queue: takes up to three events per cycle, hands out one per cycle on pop.
// Depends on tkd_pkg for evt_type; DEPTH must be a power of two, at least 4.
module tkd_evq #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [1:0]                         push_n,
   input  wire tkd_pkg::evt_type [tkd_pkg::MaxEvents-1:0] push_evt,
   input  wire logic                               pop,
   output tkd_pkg::evt_type                        head,
   output logic [$clog2(DEPTH+1)-1:0]              count
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH+1);

   tkd_pkg::evt_type   mem_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(push_n);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + CW'(push_n) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < tkd_pkg::MaxEvents; k++) begin
         if (2'(k) < push_n) begin
            mem_ff[wr_ptr_ff + AW'(k)] <= push_evt[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: design/two_key_debounce_long_press_core.sv
`default_nettype none
// Channel  | Dir | Handshake        | Payload
// req_     | in  | tvalid/tready    | tdata[0] select_level, tdata[1] nav_level
// rsp_     | out | tvalid/tready    | tdata[3:0] key_code, [5:4] key_action; tlast
// csr_     | in  | psel/penable/... | 5 registers at 4*i, pready tied high
//
// One tick per cycle is taken while req_tready is high: state update and event
// generation happen at the accepting edge, events land in the queue in the same edge.
// A tick gives up to three events; the queue head drains one per cycle under rsp_tready.
// req_tready is high while the queue has room for three events.
// Synchronous active-high reset; no clearing pass, ready in the first cycle after reset.
// Depends on tkd_pkg, tkd_csr, tkd_step and tkd_evq.
module two_key_debounce_long_press_core #(
   parameter int unsigned EVQ_DEPTH = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,   // select_level, nav_level
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [7:0]                     rsp_tdata,   // key_code, key_action
   output logic                                rsp_tlast,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [tkd_pkg::AddrWidth-1:0]  csr_paddr,
   input  wire logic [tkd_pkg::DataWidth-1:0]  csr_pwdata,
   output logic      [tkd_pkg::DataWidth-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int unsigned CW = $clog2(EVQ_DEPTH+1);

   tkd_pkg::cfg_type    cfg;
   tkd_pkg::state_type  state_ff, state_in;
   tkd_pkg::state_type  state_nxt;
   tkd_pkg::evt_type [tkd_pkg::MaxEvents-1:0] evts;
   tkd_pkg::evt_type    head;
   logic [1:0]          evt_count;
   logic [1:0]          push_n;
   logic [CW-1:0]       q_count;
   logic                accept;
   logic                pop;

   tkd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tkd_step u_step (
      .state_cur    (state_ff),
      .cfg          (cfg),
      .select_level (req_tdata[0]),
      .nav_level    (req_tdata[1]),
      .state_nxt    (state_nxt),
      .evts         (evts),
      .evt_count    (evt_count)
   );

   tkd_evq #(
      .DEPTH (EVQ_DEPTH)
   ) u_evq (
      .clock    (clock),
      .reset    (reset),
      .push_n   (push_n),
      .push_evt (evts),
      .pop      (pop),
      .head     (head),
      .count    (q_count)
   );

   assign req_tready = (q_count <= CW'(EVQ_DEPTH - tkd_pkg::MaxEvents));
   assign accept     = req_tvalid & req_tready;
   assign push_n     = accept ? evt_count : 2'd0;
   assign rsp_tvalid = (q_count != '0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tdata  = {2'b00, head.key_action, head.key_code};
   assign rsp_tlast  = head.last_event;
   assign state_in   = accept ? state_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tkd_pkg::STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CW'(EVQ_DEPTH))
      else $error("event queue count above depth");

   a_tick_whole: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |-> (q_count >= CW'(2)))
      else $error("rest of a tick's events missing from queue");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:4] != 2'd3))
      else $error("undefined key action on result");

   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready)
      |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("waiting result changed before it was taken");
`endif

endmodule
`default_nettype wire
